// ===== rtl/core/clipped_circle_outline_raster_unit_defines.svh =====
// Assertion macros for the clipped circle outline raster unit.
// CCR_ASSERT expects clk_i and rst_ni in scope; CCR_ASSERT_ALWAYS expects clk_i.
`ifndef CLIPPED_CIRCLE_OUTLINE_RASTER_UNIT_DEFINES_SVH
`define CLIPPED_CIRCLE_OUTLINE_RASTER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define CCR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("ccr assertion failed");
`define CCR_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("ccr invariant failed");
`else
`define CCR_ASSERT(lbl, prop)
`define CCR_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// ===== rtl/core/ccr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ccr_pkg;

  localparam int unsigned MAX_WIDTH_DEF  = 1024;
  localparam int unsigned MAX_HEIGHT_DEF = 1024;

  localparam int unsigned CANVAS_W  = 11;
  localparam int unsigned DIM_W     = 13;
  localparam int unsigned COORD_W   = 13;
  localparam int unsigned RADIUS_W  = 11;
  localparam int unsigned PT_W      = 14;
  localparam int unsigned ADDR_W    = 20;
  localparam int unsigned COLOR_W   = 32;
  localparam int unsigned S_DATA_W  = 72;
  localparam int unsigned M_DATA_W  = 120;
  localparam int unsigned PADDR_W   = 3;

  localparam logic [CANVAS_W-1:0] WIDTH_RST  = 11'd640;
  localparam logic [CANVAS_W-1:0] HEIGHT_RST = 11'd480;

  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } op_e;

  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_e;

  typedef struct packed {
    logic signed [PT_W-1:0] col;
    logic signed [PT_W-1:0] row;
  } point_t;

  typedef struct packed {
    point_t [3:0]         pt;
    logic [COLOR_W-1:0]   color;
    logic                 done;
  } stage_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic              valid;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/core/ccr_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ccr_cfg #(
  parameter int unsigned MAX_WIDTH  = ccr_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = ccr_pkg::MAX_HEIGHT_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [ccr_pkg::PADDR_W-1:0]    paddr,
  input  wire logic [31:0]                    pwdata,
  output logic      [31:0]                    prdata,
  output logic                                pready,
  output logic      [ccr_pkg::DIM_W-1:0]      width_o,
  output logic      [ccr_pkg::DIM_W-1:0]      height_o
);

  localparam logic [ccr_pkg::DIM_W-1:0] MaxW = ccr_pkg::DIM_W'(MAX_WIDTH);
  localparam logic [ccr_pkg::DIM_W-1:0] MaxH = ccr_pkg::DIM_W'(MAX_HEIGHT);

  logic [ccr_pkg::CANVAS_W-1:0] width_q, width_d;
  logic [ccr_pkg::CANVAS_W-1:0] height_q, height_d;
  logic                         wr_en;
  ccr_pkg::reg_e                sel;
  logic [ccr_pkg::DIM_W-1:0]    width_ext, height_ext;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign sel    = ccr_pkg::reg_e'(paddr[2]);

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (wr_en) begin
      case (sel)
        ccr_pkg::REG_WIDTH:  width_d  = pwdata[ccr_pkg::CANVAS_W-1:0];
        ccr_pkg::REG_HEIGHT: height_d = pwdata[ccr_pkg::CANVAS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= ccr_pkg::WIDTH_RST;
      height_q <= ccr_pkg::HEIGHT_RST;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
    end
  end

  always_comb begin
    case (sel)
      ccr_pkg::REG_WIDTH:  prdata = 32'(width_q);
      ccr_pkg::REG_HEIGHT: prdata = 32'(height_q);
      default:             prdata = '0;
    endcase
  end

  // clip limits saturate at the frame buffer maximum
  assign width_ext  = ccr_pkg::DIM_W'(width_q);
  assign height_ext = ccr_pkg::DIM_W'(height_q);
  assign width_o    = (width_ext > MaxW) ? MaxW : width_ext;
  assign height_o   = (height_ext > MaxH) ? MaxH : height_ext;

endmodule

`default_nettype wire

// ===== rtl/core/ccr_step.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ccr_step (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  fire_i,
  input  wire ccr_pkg::op_e                          op_i,
  input  wire logic signed [ccr_pkg::COORD_W-1:0]    center_x_i,
  input  wire logic signed [ccr_pkg::COORD_W-1:0]    center_y_i,
  input  wire logic        [ccr_pkg::RADIUS_W-1:0]   radius_i,
  input  wire logic        [ccr_pkg::COLOR_W-1:0]    color_i,
  input  wire logic                                  stg_move_i,
  output logic                                       stg_vld_o,
  output ccr_pkg::stage_t                            stg_o,
  output logic                                       active_o
);

  logic signed [12:0] cx_q, cx_d, cy_q, cy_d;
  logic signed [12:0] x_q, x_d;
  logic        [11:0] y_q, y_d;
  logic signed [15:0] err_q, err_d;
  logic        [31:0] color_q, color_d;
  logic               active_q, active_d;
  logic               stg_vld_q, stg_vld_d;
  ccr_pkg::stage_t    stg_q, stg_d;

  logic               take_step;
  logic               cond_y, cond_x;
  logic        [11:0] y1;
  logic signed [12:0] x1;
  logic signed [15:0] e1, e2;
  logic signed [13:0] cx14, cy14, x14, y14;

  assign take_step = fire_i && (op_i == ccr_pkg::OP_STEP) && active_q;

  // one midpoint iteration
  always_comb begin
    cond_y = err_q <= $signed({4'b0, y_q});
    y1     = cond_y ? (y_q + 12'd1) : y_q;
    e1     = cond_y ? (err_q + $signed({3'b0, y1, 1'b1})) : err_q;
    cond_x = (err_q > $signed({{3{x_q[12]}}, x_q})) || (e1 > $signed({4'b0, y1}));
    x1     = cond_x ? (x_q + 13'sd1) : x_q;
    e2     = cond_x ? (e1 + $signed({{2{x1[12]}}, x1, 1'b1})) : e1;
  end

  always_comb begin
    cx14 = {cx_q[12], cx_q};
    cy14 = {cy_q[12], cy_q};
    x14  = {x_q[12], x_q};
    y14  = {2'b0, y_q};
    stg_d              = stg_q;
    stg_d.pt[0].col    = cx14 - x14;
    stg_d.pt[0].row    = cy14 + y14;
    stg_d.pt[1].col    = cx14 - y14;
    stg_d.pt[1].row    = cy14 - x14;
    stg_d.pt[2].col    = cx14 + x14;
    stg_d.pt[2].row    = cy14 - y14;
    stg_d.pt[3].col    = cx14 + y14;
    stg_d.pt[3].row    = cy14 + x14;
    stg_d.color        = color_q;
    stg_d.done         = !x1[12];
  end

  always_comb begin
    cx_d     = cx_q;
    cy_d     = cy_q;
    x_d      = x_q;
    y_d      = y_q;
    err_d    = err_q;
    color_d  = color_q;
    active_d = active_q;
    if (fire_i && (op_i == ccr_pkg::OP_START)) begin
      cx_d     = center_x_i;
      cy_d     = center_y_i;
      x_d      = -$signed({2'b0, radius_i});
      y_d      = '0;
      err_d    = 16'sd2 - $signed({4'b0, radius_i, 1'b0});
      color_d  = color_i;
      active_d = 1'b1;
    end else if (take_step) begin
      x_d      = x1;
      y_d      = y1;
      err_d    = e2;
      active_d = x1[12];
    end
  end

  always_comb begin
    stg_vld_d = stg_vld_q;
    if (take_step) begin
      stg_vld_d = 1'b1;
    end else if (stg_move_i) begin
      stg_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q      <= '0;
      cy_q      <= '0;
      x_q       <= '0;
      y_q       <= '0;
      err_q     <= '0;
      color_q   <= '0;
      active_q  <= 1'b0;
      stg_vld_q <= 1'b0;
    end else begin
      cx_q      <= cx_d;
      cy_q      <= cy_d;
      x_q       <= x_d;
      y_q       <= y_d;
      err_q     <= err_d;
      color_q   <= color_d;
      active_q  <= active_d;
      stg_vld_q <= stg_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_step) begin
      stg_q <= stg_d;
    end
  end

  assign stg_vld_o = stg_vld_q;
  assign stg_o     = stg_q;
  assign active_o  = active_q;

endmodule

`default_nettype wire

// ===== rtl/core/ccr_point.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ccr_point (
  input  wire ccr_pkg::point_t                 pt_i,
  input  wire logic [ccr_pkg::DIM_W-1:0]       width_i,
  input  wire logic [ccr_pkg::DIM_W-1:0]       height_i,
  output ccr_pkg::res_t                        res_o
);

  logic        in_x, in_y;
  logic [11:0] row_u;
  logic [12:0] col_u;
  logic [24:0] prod;
  logic [24:0] sum;

  assign in_x  = !pt_i.col[13] && (pt_i.col[12:0] < width_i);
  assign in_y  = !pt_i.row[13] && (pt_i.row[12:0] < height_i);
  assign row_u = pt_i.row[11:0];
  assign col_u = pt_i.col[12:0];
  assign prod  = 25'(row_u) * 25'(width_i);
  assign sum   = prod + 25'(col_u);

  assign res_o.valid = in_x && in_y;
  assign res_o.addr  = (in_x && in_y) ? sum[ccr_pkg::ADDR_W-1:0] : '0;

endmodule

`default_nettype wire

// ===== rtl/core/clipped_circle_outline_raster_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "clipped_circle_outline_raster_unit_defines.svh"

// Midpoint circle outline rasterizer. A start transaction (tuser = 0) loads center,
// radius and color and returns nothing; each step transaction (tuser = 1) runs one
// iteration and returns the four symmetric points as clipped row-major addresses,
// with tlast set on the final iteration. A step while no circle runs is dropped.
// One transaction is taken every cycle unless m_axis_tready back-pressure stalls it:
// the iteration update is a few narrow adds and compares into the state registers,
// the points go through a stage register, and the clip test plus one row*width
// multiply per point fill the output register. The user must write canvas size over
// APB (width at 0x0, height at 0x4) only while the unit is idle; the unit does not enforce it.
module clipped_circle_outline_raster_unit #(
  parameter int unsigned MAX_WIDTH  = ccr_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = ccr_pkg::MAX_HEIGHT_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // [12:0] center_x, [25:13] center_y, [36:26] radius, [68:37] color
  input  wire logic [ccr_pkg::S_DATA_W-1:0]      s_axis_tdata,
  // [0] opcode
  input  wire logic                              s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // [0] point0_valid, [20:1] point0_addr, [21] point1_valid, [41:22] point1_addr,
  // [42] point2_valid, [62:43] point2_addr, [63] point3_valid, [83:64] point3_addr,
  // [115:84] pixel_value
  output logic      [ccr_pkg::M_DATA_W-1:0]      m_axis_tdata,
  output logic                                   m_axis_tlast,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [ccr_pkg::PADDR_W-1:0]       paddr,
  input  wire logic [31:0]                       pwdata,
  output logic      [31:0]                       prdata,
  output logic                                   pready
);

  logic [ccr_pkg::DIM_W-1:0] width, height;
  logic                      fire, stg_move, out_free;
  logic                      stg_vld, active;
  ccr_pkg::stage_t           stg;
  ccr_pkg::op_e              op;
  ccr_pkg::res_t [3:0]       res;

  logic                      out_vld_q, out_vld_d;
  ccr_pkg::res_t [3:0]       out_res_q;
  logic [31:0]               out_color_q;
  logic                      out_done_q;

  ccr_cfg #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .width_o (width),
    .height_o(height)
  );

  assign out_free      = !out_vld_q || m_axis_tready;
  assign stg_move      = stg_vld && out_free;
  assign s_axis_tready = !stg_vld || out_free;
  assign fire          = s_axis_tvalid && s_axis_tready;
  assign op            = ccr_pkg::op_e'(s_axis_tuser);

  ccr_step u_step (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (fire),
    .op_i      (op),
    .center_x_i(s_axis_tdata[12:0]),
    .center_y_i(s_axis_tdata[25:13]),
    .radius_i  (s_axis_tdata[36:26]),
    .color_i   (s_axis_tdata[68:37]),
    .stg_move_i(stg_move),
    .stg_vld_o (stg_vld),
    .stg_o     (stg),
    .active_o  (active)
  );

  for (genvar k = 0; k < 4; k++) begin : g_pt
    ccr_point u_point (
      .pt_i    (stg.pt[k]),
      .width_i (width),
      .height_i(height),
      .res_o   (res[k])
    );
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (stg_move) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stg_move) begin
      out_res_q   <= res;
      out_color_q <= stg.color;
      out_done_q  <= stg.done;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {4'b0, out_color_q, out_res_q};
  assign m_axis_tlast  = out_done_q;

  `CCR_ASSERT(a_move_fills_out, stg_move |=> out_vld_q)
  `CCR_ASSERT(a_idle_step_dropped, (fire && op == ccr_pkg::OP_STEP && !active) |=> (stg_vld == $past(stg_vld && !stg_move)))
  `CCR_ASSERT(a_clipped_addr_zero, (out_vld_q && !out_res_q[0].valid) |-> (out_res_q[0].addr == '0))
  `CCR_ASSERT_ALWAYS(a_open_step_keeps_active, (stg_vld && !stg.done) |-> active)

endmodule

`default_nettype wire
